@@ design/assert_macros.svh @@
// Assertion macros shared by the ring maintenance RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define CRM_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/crm_pkg.sv @@
// Package for the ring maintenance block: message kinds, register indexes,
// payload structs and the modular ring membership test. No dependencies.
`timescale 1ns / 1ps

package crm_pkg;

   localparam int CRM_QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   typedef enum logic [1:0] {
      KIND_JOIN      = 2'd0,
      KIND_NOTIFY    = 2'd1,
      KIND_STABILIZE = 2'd2
   } msg_kind_type;

   typedef enum logic [1:0] {
      REG_SELF_ID   = 2'd0,
      REG_SELF_IP   = 2'd1,
      REG_SELF_PORT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [15:0] id;
   } peer_type;

   typedef struct packed {
      msg_kind_type kind;
      logic [31:0]  dest_ip;
      logic [15:0]  dest_port;
      logic [31:0]  body_ip;
      logic [15:0]  body_port;
      logic [15:0]  body_id;
   } msg_type;

   // One classified item: one or two outgoing messages
   typedef struct packed {
      msg_type first;
      msg_type second;
      logic    two;
   } job_type;

   // v lies in the half-open arc [s, e) measured from s, modulo 2^16
   function automatic logic ring_between(input logic [15:0] s, input logic [15:0] e,
                                         input logic [15:0] v);
      logic [15:0] eo;
      logic [15:0] vo;
      eo = e - s;
      vo = v - s;
      return vo < eo;
   endfunction

endpackage

@@ design/crm_if.sv @@
// Handshake channels of the ring maintenance block: request and response.
// Depends on nothing; payload fields follow the message formats.
`timescale 1ns / 1ps

interface crm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] peer_ip;
   logic [15:0] peer_port;
   logic [15:0] peer_id;

   modport source (output valid, op, peer_ip, peer_port, peer_id, input ready);
   modport sink (input valid, op, peer_ip, peer_port, peer_id, output ready);
endinterface

interface crm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  msg_kind;
   logic [31:0] dest_ip;
   logic [15:0] dest_port;
   logic [31:0] body_ip;
   logic [15:0] body_port;
   logic [15:0] body_id;
   logic        last;

   modport source (output valid, msg_kind, dest_ip, dest_port, body_ip, body_port,
                   body_id, last, input ready);
   modport sink (input valid, msg_kind, dest_ip, dest_port, body_ip, body_port,
                 body_id, last, output ready);
endinterface

@@ design/crm_csr.sv @@
// Configuration registers of the ring node (self id, address and port).
// Depends on crm_pkg; APB-style write and read access.
`timescale 1ns / 1ps

module crm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [crm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [crm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [crm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output crm_pkg::peer_type               cfg
);
   import crm_pkg::*;

   logic [15:0]   self_id_ff;
   logic [31:0]   self_ip_ff;
   logic [15:0]   self_port_ff;
   logic          wr_en;
   reg_index_type reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   // Write the addressed register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff   <= '0;
         self_ip_ff   <= '0;
         self_port_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SELF_ID:   self_id_ff   <= pwdata[15:0];
            REG_SELF_IP:   self_ip_ff   <= pwdata[31:0];
            REG_SELF_PORT: self_port_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_SELF_ID:   prdata = {16'd0, self_id_ff};
         REG_SELF_IP:   prdata = self_ip_ff;
         REG_SELF_PORT: prdata = {16'd0, self_port_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.id   = self_id_ff;
   assign cfg.ip   = self_ip_ff;
   assign cfg.port = self_port_ff;

endmodule

@@ design/crm_front.sv @@
// Front end: accepts ring messages, updates successor and predecessor and
// builds the outgoing messages. Depends on crm_pkg, crm_if and the macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crm_front (
   input  logic              clock,
   input  logic              reset,
   crm_req_if.sink           req,
   input  crm_pkg::peer_type cfg,
   input  logic              queue_full,
   output logic              job_push,
   output crm_pkg::job_type  job
);
   import crm_pkg::*;

   logic     succ_valid_ff, succ_valid_in;
   logic     pred_valid_ff, pred_valid_in;
   peer_type succ_ff, succ_in;
   peer_type pred_ff, pred_in;
   peer_type peer;
   logic     accept;
   logic     succ_hit;
   logic     pred_hit;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign peer.ip   = req.peer_ip;
   assign peer.port = req.peer_port;
   assign peer.id   = req.peer_id;

   assign succ_hit = ring_between(cfg.id, succ_ff.id, peer.id);
   assign pred_hit = ring_between(pred_ff.id, cfg.id, peer.id);

   // Classify the item and build its messages
   always_comb begin
      succ_valid_in = succ_valid_ff;
      pred_valid_in = pred_valid_ff;
      succ_in       = succ_ff;
      pred_in       = pred_ff;
      job_push      = 1'b0;
      job           = '0;
      case (req.op)
         KIND_JOIN: begin
            job_push = accept;
            if (!succ_valid_ff || succ_hit || succ_ff.id == cfg.id) begin
               job.first.kind      = KIND_NOTIFY;
               job.first.dest_ip   = peer.ip;
               job.first.dest_port = peer.port;
               if (succ_valid_ff) begin
                  job.first.body_ip   = succ_ff.ip;
                  job.first.body_port = succ_ff.port;
                  job.first.body_id   = succ_ff.id;
               end else begin
                  job.first.body_ip   = cfg.ip;
                  job.first.body_port = cfg.port;
                  job.first.body_id   = cfg.id;
               end
               job.second.kind      = KIND_STABILIZE;
               job.second.dest_ip   = peer.ip;
               job.second.dest_port = peer.port;
               job.second.body_ip   = cfg.ip;
               job.second.body_port = cfg.port;
               job.second.body_id   = cfg.id;
               job.two              = 1'b1;
               succ_valid_in        = accept ? 1'b1 : succ_valid_ff;
               succ_in              = accept ? peer : succ_ff;
            end else begin
               // forward the join unchanged towards the successor
               job.first.kind      = KIND_JOIN;
               job.first.dest_ip   = succ_ff.ip;
               job.first.dest_port = succ_ff.port;
               job.first.body_ip   = peer.ip;
               job.first.body_port = peer.port;
               job.first.body_id   = peer.id;
            end
         end
         KIND_NOTIFY: begin
            if (!succ_valid_ff || (succ_hit && peer.id != cfg.id)) begin
               job_push            = accept;
               job.first.kind      = KIND_STABILIZE;
               job.first.dest_ip   = peer.ip;
               job.first.dest_port = peer.port;
               job.first.body_ip   = cfg.ip;
               job.first.body_port = cfg.port;
               job.first.body_id   = cfg.id;
               succ_valid_in       = accept ? 1'b1 : succ_valid_ff;
               succ_in             = accept ? peer : succ_ff;
            end
         end
         KIND_STABILIZE: begin
            job_push            = accept;
            job.first.kind      = KIND_NOTIFY;
            job.first.dest_ip   = peer.ip;
            job.first.dest_port = peer.port;
            if (!pred_valid_ff || pred_hit) begin
               job.first.body_ip   = peer.ip;
               job.first.body_port = peer.port;
               job.first.body_id   = peer.id;
               pred_valid_in       = accept ? 1'b1 : pred_valid_ff;
               pred_in             = accept ? peer : pred_ff;
            end else begin
               job.first.body_ip   = pred_ff.ip;
               job.first.body_port = pred_ff.port;
               job.first.body_id   = pred_ff.id;
            end
         end
         default: ;
      endcase
   end

   // Hold the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         succ_valid_ff <= 1'b0;
         pred_valid_ff <= 1'b0;
      end else begin
         succ_valid_ff <= succ_valid_in;
         pred_valid_ff <= pred_valid_in;
      end
   end

   // Neighbour entries are only read once their flag is set
   always_ff @(posedge clock) begin
      succ_ff <= succ_in;
      pred_ff <= pred_in;
   end

   `CRM_ASSERT_NEXT(a_join_sets_succ, accept && req.op == KIND_JOIN, succ_valid_ff, "join left no successor")
   `CRM_ASSERT_NEXT(a_stab_sets_pred, accept && req.op == KIND_STABILIZE, pred_valid_ff, "stabilize left no predecessor")
   `CRM_ASSERT(a_push_needs_accept, job_push, accept, "job queued without an accepted item")

endmodule

@@ design/crm_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on crm_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crm_fifo #(
   parameter int Depth = crm_pkg::CRM_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crm_pkg::job_type wdata,
   output logic             full,
   input  logic             pop,
   output crm_pkg::job_type rdata,
   output logic             not_empty
);
   import crm_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign rdata     = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   `CRM_ASSERT(a_no_overflow, push, !full, "push into a full job queue")
   `CRM_ASSERT(a_no_underflow, pop, not_empty, "pop from an empty job queue")

endmodule

@@ design/crm_back.sv @@
// Back end: takes queued jobs and sends their one or two messages through
// an output register. Depends on crm_pkg, crm_if and the macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crm_back (
   input  logic             clock,
   input  logic             reset,
   input  crm_pkg::job_type head,
   input  logic             head_valid,
   output logic             pop,
   crm_rsp_if.source        rsp
);
   import crm_pkg::*;

   job_type job_ff, job_in;
   logic    job_valid_ff, job_valid_in;
   logic    sel_ff, sel_in;
   logic    out_valid_ff, out_valid_in;
   msg_type out_ff;
   logic    out_last_ff;
   msg_type cur;
   logic    cur_last;
   logic    load;
   logic    emit;
   logic    done;

   assign load     = !out_valid_ff || rsp.ready;
   assign emit     = load && job_valid_ff;
   assign cur      = sel_ff ? job_ff.second : job_ff.first;
   assign cur_last = !job_ff.two || sel_ff;
   assign done     = emit && cur_last;
   assign pop      = head_valid && (!job_valid_ff || done);

   // Step through the held job and take the next one when it is finished
   always_comb begin
      job_in       = pop ? head : job_ff;
      job_valid_in = pop ? 1'b1 : (done ? 1'b0 : job_valid_ff);
      if (pop || done) begin
         sel_in = 1'b0;
      end else begin
         sel_in = emit ? 1'b1 : sel_ff;
      end
      out_valid_in = load ? job_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         out_ff      <= cur;
         out_last_ff <= cur_last;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.msg_kind  = out_ff.kind;
   assign rsp.dest_ip   = out_ff.dest_ip;
   assign rsp.dest_port = out_ff.dest_port;
   assign rsp.body_ip   = out_ff.body_ip;
   assign rsp.body_port = out_ff.body_port;
   assign rsp.body_id   = out_ff.body_id;
   assign rsp.last      = out_last_ff;

   `CRM_ASSERT(a_single_msg_sel, job_valid_ff && !job_ff.two, !sel_ff, "second message selected on a single-message job")

endmodule

@@ design/chord_ring_maintenance.sv @@
// Ring maintenance node, one Chord-style ring member with 16-bit ids.
// Channels: req_chan carries join, notify and stabilize messages (op, peer
// address, port and id); rsp_chan carries the outgoing messages, last set on
// the final one for each request. Both use valid/ready; a transfer happens
// when both are high. The APB port sets self id, address and port and may be
// written only while the node is idle.
// The first message of a request passes the job queue, the back end's job
// register and the output register. One request per cycle is taken while the
// queue has room, and one response message per cycle goes out while rsp_chan
// ready is high; the two messages of a join go out one after the other.
// A request that causes no message (notify that loses, op 3) leaves nothing.
// Reset clears the successor and predecessor flags, the registers and queue.
// When the receiver stalls, the output register holds, the back end stops,
// the job queue fills, and req_chan ready falls once the queue is full.
// Depends on crm_pkg, crm_if, crm_csr, crm_front, crm_fifo and crm_back.
`timescale 1ns / 1ps

module chord_ring_maintenance #(
   parameter int QueueDepth = crm_pkg::CRM_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   crm_req_if.sink                        req_chan,
   crm_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [crm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [crm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [crm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import crm_pkg::*;

   peer_type cfg;
   job_type  push_job;
   job_type  head_job;
   logic     push;
   logic     pop;
   logic     full;
   logic     not_empty;

   crm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg),
      .queue_full (full),
      .job_push   (push),
      .job        (push_job)
   );

   crm_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     (push_job),
      .full      (full),
      .pop       (pop),
      .rdata     (head_job),
      .not_empty (not_empty)
   );

   crm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .head_valid (not_empty),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

@@ tb/ring_msg_checker.sv @@
// Response checker for the ring maintenance node: watches the request, response
// and APB channels, predicts the outgoing messages and compares them in order.
// Depends on crm_pkg and the channel interfaces in crm_if.
`timescale 1ns / 1ps

module ring_msg_checker (
   input  logic                           clock,
   input  logic                           reset,
   crm_req_if                             req_mon,
   crm_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [crm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [crm_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             error_count,
   output int                             outstanding
);
   import crm_pkg::*;

   typedef struct packed {
      msg_type msg;
      logic    last;
   } out_msg_rec;

   // Node identity as programmed over APB
   logic [15:0] node_id;
   logic [31:0] node_ip;
   logic [15:0] node_port;

   // Ring neighbours as the node should hold them
   logic       succ_ok;
   peer_type   succ_peer;
   logic       pred_ok;
   peer_type   pred_peer;

   out_msg_rec pending_msgs[$];
   int         errors;

   initial begin
      errors = 0;
   end

   // Offset of pt from the arc start is below the offset of the arc end
   function automatic logic on_arc(input logic [15:0] from, input logic [15:0] to,
                                   input logic [15:0] pt);
      logic [15:0] span;
      logic [15:0] pt_offset;
      span      = to - from;
      pt_offset = pt - from;
      return pt_offset < span;
   endfunction

   function automatic void queue_msg(input msg_kind_type k, input logic [31:0] dip,
                                     input logic [15:0] dport, input logic [31:0] bip,
                                     input logic [15:0] bport, input logic [15:0] bid,
                                     input logic fin);
      out_msg_rec rec;
      rec.msg.kind      = k;
      rec.msg.dest_ip   = dip;
      rec.msg.dest_port = dport;
      rec.msg.body_ip   = bip;
      rec.msg.body_port = bport;
      rec.msg.body_id   = bid;
      rec.last          = fin;
      pending_msgs.push_back(rec);
   endfunction

   // Update the neighbour entries for one request and queue what it sends
   task automatic advance_ring(input logic [1:0] op, input peer_type p);
      if (op == KIND_JOIN) begin
         if (!succ_ok || on_arc(node_id, succ_peer.id, p.id) || succ_peer.id == node_id) begin
            if (succ_ok)
               queue_msg(KIND_NOTIFY, p.ip, p.port, succ_peer.ip, succ_peer.port,
                         succ_peer.id, 1'b0);
            else
               queue_msg(KIND_NOTIFY, p.ip, p.port, node_ip, node_port, node_id, 1'b0);
            succ_ok   = 1'b1;
            succ_peer = p;
            queue_msg(KIND_STABILIZE, p.ip, p.port, node_ip, node_port, node_id, 1'b1);
         end else begin
            queue_msg(KIND_JOIN, succ_peer.ip, succ_peer.port, p.ip, p.port, p.id, 1'b1);
         end
      end else if (op == KIND_NOTIFY) begin
         if (!succ_ok || (on_arc(node_id, succ_peer.id, p.id) && p.id != node_id)) begin
            succ_ok   = 1'b1;
            succ_peer = p;
            queue_msg(KIND_STABILIZE, p.ip, p.port, node_ip, node_port, node_id, 1'b1);
         end
      end else if (op == KIND_STABILIZE) begin
         if (!pred_ok || on_arc(pred_peer.id, node_id, p.id)) begin
            pred_ok   = 1'b1;
            pred_peer = p;
         end
         queue_msg(KIND_NOTIFY, p.ip, p.port, pred_peer.ip, pred_peer.port, pred_peer.id,
                   1'b1);
      end
      // the unused op code changes nothing and sends nothing
   endtask

   always @(posedge clock) begin : watch
      out_msg_rec want;
      peer_type   got_peer;
      if (reset) begin
         node_id   = '0;
         node_ip   = '0;
         node_port = '0;
         succ_ok   = 1'b0;
         succ_peer = '0;
         pred_ok   = 1'b0;
         pred_peer = '0;
         pending_msgs.delete();
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_SELF_ID:   node_id   = pwdata[15:0];
               REG_SELF_IP:   node_ip   = pwdata[31:0];
               REG_SELF_PORT: node_port = pwdata[15:0];
               default: ;
            endcase
         end

         // Compare each response transfer with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_msgs.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("tb: unexpected message kind=%0d dest=%h:%h body=%h:%h id=%h last=%b",
                           rsp_mon.msg_kind, rsp_mon.dest_ip, rsp_mon.dest_port,
                           rsp_mon.body_ip, rsp_mon.body_port, rsp_mon.body_id,
                           rsp_mon.last);
            end else begin
               want = pending_msgs.pop_front();
               if (rsp_mon.msg_kind !== want.msg.kind ||
                   rsp_mon.dest_ip !== want.msg.dest_ip ||
                   rsp_mon.dest_port !== want.msg.dest_port ||
                   rsp_mon.body_ip !== want.msg.body_ip ||
                   rsp_mon.body_port !== want.msg.body_port ||
                   rsp_mon.body_id !== want.msg.body_id ||
                   rsp_mon.last !== want.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("tb: mismatch exp kind=%0d dest=%h:%h body=%h:%h id=%h last=%b",
                              want.msg.kind, want.msg.dest_ip, want.msg.dest_port,
                              want.msg.body_ip, want.msg.body_port, want.msg.body_id,
                              want.last);
                     $display("tb: mismatch got kind=%0d dest=%h:%h body=%h:%h id=%h last=%b",
                              rsp_mon.msg_kind, rsp_mon.dest_ip, rsp_mon.dest_port,
                              rsp_mon.body_ip, rsp_mon.body_port, rsp_mon.body_id,
                              rsp_mon.last);
                  end
               end
            end
         end

         // Predict on each request transfer
         if (req_mon.valid && req_mon.ready) begin
            got_peer.ip   = req_mon.peer_ip;
            got_peer.port = req_mon.peer_port;
            got_peer.id   = req_mon.peer_id;
            advance_ring(req_mon.op, got_peer);
         end
      end
      error_count <= errors;
      outstanding <= pending_msgs.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the ring maintenance testbench: clock, reset, APB set-up, request
// stimulus in bursts and a stalling receiver; verdict from ring_msg_checker.
// Depends on crm_pkg, crm_if, chord_ring_maintenance and ring_msg_checker.
`timescale 1ns / 1ps

module testbench;
   import crm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int          fail_count;
   int          backlog;
   logic        req_driving;
   int          burst_left;
   logic [15:0] cur_self_id;
   logic [15:0] recent_ids [8];
   logic [2:0]  recent_wr;
   int          rdy_cycle;
   int          rdy_mode;

   crm_req_if req_chan ();
   crm_rsp_if rsp_chan ();

   chord_ring_maintenance u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   ring_msg_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .error_count (fail_count),
      .outstanding (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver: stall pattern changes mode every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rdy_cycle      <= 0;
      end else begin
         rdy_cycle <= rdy_cycle + 1;
         if (rdy_cycle % 97 == 0)
            rdy_mode <= $urandom_range(0, 3);
         case (rdy_mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
            2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= ((rdy_cycle % 5) < 2);
         endcase
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_identity(input logic [15:0] id, input logic [31:0] ip,
                               input logic [15:0] port);
      csr_write(REG_SELF_ID, {16'h0, id});
      csr_write(REG_SELF_IP, ip);
      csr_write(REG_SELF_PORT, {16'h0, port});
      cur_self_id = id;
   endtask

   // One request transfer, then, when the burst runs out, a random gap that may be empty
   task automatic send_request(input logic [1:0] op, input logic [31:0] ip,
                               input logic [15:0] port, input logic [15:0] id);
      int gap;
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.peer_ip   <= ip;
      req_chan.peer_port <= port;
      req_chan.peer_id   <= id;
      req_driving = 1'b1;
      recent_ids[recent_wr] = id;
      recent_wr = recent_wr + 3'd1;
      do @(posedge clock); while (!req_chan.ready);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) == 0)
            gap = $urandom_range(8, 20);
         else
            gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            req_driving = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold until every predicted message has gone out
   task automatic wait_idle();
      if (req_driving) begin
         req_chan.valid <= 1'b0;
         req_driving = 1'b0;
      end
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Random request, ids biased towards self, the wrap point and recent peers
   task automatic pick_request(output logic [1:0] op, output logic [31:0] ip,
                               output logic [15:0] port, output logic [15:0] id);
      int r;
      r = $urandom_range(0, 19);
      if (r < 7)       op = KIND_JOIN;
      else if (r < 13) op = KIND_NOTIFY;
      else if (r < 19) op = KIND_STABILIZE;
      else             op = OP_UNUSED;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2: id = 16'($urandom_range(0, 65535));
         3:       id = cur_self_id;
         4:       id = $urandom_range(0, 1) ? 16'(cur_self_id + $urandom_range(1, 3))
                                            : 16'(cur_self_id - $urandom_range(1, 3));
         5:       id = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
         default: id = 16'(recent_ids[3'($urandom_range(0, 7))] + $urandom_range(0, 2) - 1);
      endcase
      if ($urandom_range(0, 7) == 0)
         ip = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      else
         ip = $urandom;
      if ($urandom_range(0, 7) == 0)
         port = $urandom_range(0, 1) ? 16'h0 : 16'hFFFF;
      else
         port = 16'($urandom_range(0, 65535));
   endtask

   initial begin
      logic [1:0]  op;
      logic [31:0] ip;
      logic [15:0] port;
      logic [15:0] id;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_chan.valid     = 1'b0;
      req_chan.op        = KIND_JOIN;
      req_chan.peer_ip   = '0;
      req_chan.peer_port = '0;
      req_chan.peer_id   = '0;
      rsp_chan.ready     = 1'b0;
      rdy_mode           = 0;
      rdy_cycle          = 0;
      req_driving        = 1'b0;
      burst_left         = 4;
      recent_wr          = '0;
      cur_self_id        = '0;
      recent_ids         = '{default: '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty neighbours first, then arc edges, self ids and extremes
      set_identity(16'h1000, 32'hC0A8_0001, 16'h1F90);
      send_request(KIND_JOIN,      32'h0A00_0002, 16'h1388, 16'h2000);
      send_request(KIND_STABILIZE, 32'h0A00_0003, 16'h1389, 16'h0800);
      send_request(KIND_STABILIZE, 32'h0A00_0004, 16'h138A, 16'h0C00);
      send_request(KIND_STABILIZE, 32'h0A00_0005, 16'h138B, 16'h0C00);
      send_request(KIND_STABILIZE, 32'h0A00_0006, 16'h138C, 16'h1000);
      send_request(KIND_STABILIZE, 32'h0A00_0007, 16'h138D, 16'h3000);
      send_request(KIND_JOIN,      32'h0A00_0008, 16'h138E, 16'h1800);
      send_request(KIND_JOIN,      32'h0A00_0009, 16'h138F, 16'h1800);
      send_request(KIND_JOIN,      32'h0A00_000A, 16'h1390, 16'h5000);
      send_request(KIND_JOIN,      32'h0A00_000B, 16'h1391, 16'h1000);
      send_request(KIND_JOIN,      32'h0A00_000C, 16'h1392, 16'hF000);
      send_request(KIND_NOTIFY,    32'h0A00_000D, 16'h1393, 16'h1000);
      send_request(KIND_NOTIFY,    32'h0A00_000E, 16'h1394, 16'h2000);
      send_request(KIND_NOTIFY,    32'h0A00_000F, 16'h1395, 16'hFFFF);
      send_request(OP_UNUSED,      32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(KIND_JOIN,      32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(KIND_JOIN,      32'h0000_0000, 16'h0000, 16'h0000);
      send_request(KIND_STABILIZE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(KIND_STABILIZE, 32'h0000_0000, 16'h0000, 16'h0000);
      send_request(KIND_NOTIFY,    32'h0000_0000, 16'h0000, 16'h0000);

      // Random phases, each under its own identity
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0:       set_identity(16'h0000, 32'h0000_0000, 16'h0000);
            1:       set_identity(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
            default: set_identity(16'($urandom_range(0, 65535)), $urandom,
                                  16'($urandom_range(0, 65535)));
         endcase
         for (int n = 0; n < 192; n++) begin
            pick_request(op, ip, port, id);
            send_request(op, ip, port, id);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
